// ----- rtl/core/cqf_pkg.sv -----
`timescale 1ns / 1ps

package cqf_pkg;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int CAP_W    = 7;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DISPLAY = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;

   // commands from controller to datapath
   typedef struct packed {
      logic                load_out;
      logic [STATUS_W-1:0] out_status;
      logic                out_data;
      logic                out_last;
      logic                ins_first;
      logic                ins_next;
      logic                pop;
      logic                walk_start;
      logic                walk_step;
      logic                rd_walk;
   } cqf_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_empty;
      logic full;
      logic walk_last;
      logic out_free;
   } cqf_stat_type;

endpackage

// ----- rtl/core/circular_queue_fifo.sv -----
`timescale 1ns / 1ps

// Circular FIFO of signed 32-bit values with a run-time capacity.
// Request channel (req_*): opcode insert, delete or display plus the insert value.
// Response channel (rsp_*): status, data and a flag on the last result of a request.
// Capacity is written over the csr_* APB port at address 0, only while the queue is
// empty; 0 acts as 1 and values above MAX_DEPTH act as MAX_DEPTH.
// Insert and the empty/full error results appear in the cycle after accept;
// delete passes through the pop state (registered memory read of the head entry).
// Throughput: one request in flight at a time; insert every cycle when the output is
// taken; delete and display pass through extra states, and display reads its entries
// one by one, limited by the single memory read port and its registered output.
// The request side is stalled until a display has given all of its entries.
// Reset empties the queue, zeroes head and tail and sets capacity to 64; the entry
// memory is not cleared. When rsp_stall is high the result register holds its
// transaction and req_stall stays high until the result is taken.
module circular_queue_fifo #(
   parameter int MAX_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cqf_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [cqf_pkg::DATA_W-1:0]   req_insert_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cqf_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [cqf_pkg::DATA_W-1:0]   rsp_data_out,
   output logic                                rsp_last_result,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import cqf_pkg::*;

   localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_DEPTH);
   localparam logic [CAP_W-1:0] RST_CAP = CAP_W'(64);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] cap_eff;
   logic             csr_wr;
   cqf_cmd_type      cmd;
   cqf_stat_type     stat;

   // capacity register, written only while the queue is empty
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && (csr_paddr[2] == REG_CAPACITY) && stat.is_empty) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= RST_CAP;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_ff} : '0;

   // clamp capacity into 1..MAX_DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_ff > MAX_CAP) begin
         cap_eff = MAX_CAP;
      end else begin
         cap_eff = cap_ff;
      end
   end

   cqf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   cqf_dpath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cap              (cap_eff),
      .req_insert_value (req_insert_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ----- rtl/core/cqf_ctrl.sv -----
`timescale 1ns / 1ps

module cqf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [cqf_pkg::OPCODE_W-1:0]  req_opcode,
   output logic                          req_stall,
   input  cqf_pkg::cqf_stat_type         stat,
   output cqf_pkg::cqf_cmd_type          cmd
);
   import cqf_pkg::*;

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_POP      = 2'd1;
   localparam logic [1:0] S_WALK_OUT = 2'd2;
   localparam logic [1:0] S_WALK_RD  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // take a new transaction only when idle and the output register can take a result
   assign req_stall = !((state_ff == S_IDLE) && stat.out_free);
   assign accept    = req_valid && !req_stall;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_INSERT: begin
                     cmd.load_out = 1'b1;
                     cmd.out_last = 1'b1;
                     if (stat.is_empty) begin
                        cmd.ins_first  = 1'b1;
                        cmd.out_status = ST_OK;
                     end else if (stat.full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.ins_next   = 1'b1;
                        cmd.out_status = ST_OK;
                     end
                  end
                  OP_DELETE: begin
                     if (stat.is_empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  OP_DISPLAY: begin
                     if (stat.is_empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.walk_start = 1'b1;
                        state_in       = S_WALK_OUT;
                     end
                  end
                  default: begin
                     // unused opcode: no result
                  end
               endcase
            end
         end
         S_POP: begin
            // head entry was read on the accepting edge
            if (stat.out_free) begin
               cmd.load_out   = 1'b1;
               cmd.out_data   = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_status = ST_OK;
               cmd.pop        = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_WALK_OUT: begin
            cmd.rd_walk = 1'b1;
            if (stat.out_free) begin
               cmd.load_out   = 1'b1;
               cmd.out_data   = 1'b1;
               cmd.out_last   = stat.walk_last;
               cmd.out_status = ST_OK;
               if (stat.walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk_step = 1'b1;
                  state_in      = S_WALK_RD;
               end
            end
         end
         S_WALK_RD: begin
            // the memory read at the new walk pointer happens in this state
            cmd.rd_walk = 1'b1;
            state_in    = S_WALK_OUT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/cqf_dpath.sv -----
`timescale 1ns / 1ps

module cqf_dpath #(
   parameter int MAX_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cqf_pkg::CAP_W-1:0]           cap,
   input  logic signed [cqf_pkg::DATA_W-1:0]   req_insert_value,
   input  cqf_pkg::cqf_cmd_type                cmd,
   output cqf_pkg::cqf_stat_type               stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cqf_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [cqf_pkg::DATA_W-1:0]   rsp_data_out,
   output logic                                rsp_last_result
);
   import cqf_pkg::*;

   localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // next pointer, wrapping at the active capacity
   function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                            input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] nx;
      nx = CAP_W'(p) + 1'b1;
      return (nx >= c) ? '0 : PTR_W'(nx);
   endfunction

   logic signed [DATA_W-1:0] mem [MAX_DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] walk_ff, walk_in;
   logic             empty_ff, empty_in;
   logic             out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]      out_status_ff;
   logic signed [DATA_W-1:0] out_data_ff;
   logic                     out_last_ff;

   logic [PTR_W-1:0] tail_next;
   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] wr_addr;
   logic             wr_en;

   assign tail_next = adv(tail_ff, cap);
   assign rd_addr   = cmd.rd_walk ? walk_ff : head_ff;
   assign wr_en     = cmd.ins_first || cmd.ins_next;
   assign wr_addr   = cmd.ins_first ? '0 : tail_next;

   // status back to the controller
   assign stat.is_empty  = empty_ff;
   assign stat.full      = (tail_next == head_ff);
   assign stat.walk_last = (walk_ff == tail_ff);
   assign stat.out_free  = !out_valid_ff || !rsp_stall;

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_insert_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // head, tail, empty flag and walk pointer
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      walk_in  = walk_ff;
      if (cmd.ins_first) begin
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b0;
      end else if (cmd.ins_next) begin
         tail_in = tail_next;
      end else if (cmd.pop) begin
         if (head_ff == tail_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b1;
         end else begin
            head_in = adv(head_ff, cap);
         end
      end
      if (cmd.walk_start) begin
         walk_in = head_ff;
      end else if (cmd.walk_step) begin
         walk_in = adv(walk_ff, cap);
      end
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         walk_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         walk_ff      <= walk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= cmd.out_status;
         out_data_ff   <= cmd.out_data ? rd_data_ff : '0;
         out_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_data_out    = out_data_ff;
   assign rsp_last_result = out_last_ff;

endmodule
